FILE: src/dec_pkg.sv
package dec_pkg;

  // Widths of the register and of every multi-bit payload field
  localparam int CfgW   = 16;
  localparam int FieldW = 16;

  // Hit radius per unit of mass sum after reset: 1.0 in Q4.12
  localparam logic [CfgW-1:0] HitScaleRst = 16'd4096;

  // Input beat: two disc centres (Q12.4), velocities (Q10.6), masses (Q8.8)
  typedef struct packed {
    logic signed [FieldW-1:0] first_pos_x;
    logic signed [FieldW-1:0] first_pos_y;
    logic signed [FieldW-1:0] second_pos_x;
    logic signed [FieldW-1:0] second_pos_y;
    logic signed [FieldW-1:0] first_vel_x;
    logic signed [FieldW-1:0] first_vel_y;
    logic signed [FieldW-1:0] second_vel_x;
    logic signed [FieldW-1:0] second_vel_y;
    logic        [FieldW-1:0] first_mass;
    logic        [FieldW-1:0] second_mass;
    logic                     both_active;
  } in_t;

  // Output beat: response flags, new velocities, contact point
  typedef struct packed {
    logic                     hit;
    logic                     degenerate;
    logic signed [FieldW-1:0] new_first_vel_x;
    logic signed [FieldW-1:0] new_first_vel_y;
    logic signed [FieldW-1:0] new_second_vel_x;
    logic signed [FieldW-1:0] new_second_vel_y;
    logic signed [FieldW-1:0] contact_x;
    logic signed [FieldW-1:0] contact_y;
  } out_t;

  // Clamp a wide signed value to the 16-bit field range
  function automatic logic signed [FieldW-1:0] sat16(input logic signed [39:0] v);
    logic signed [FieldW-1:0] r;
    if (v > 40'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -40'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[FieldW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: src/dec_stream_if.sv
interface dec_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/disc_elastic_collision_top.sv
// Two-disc elastic collision response.
// in_i carries one pair of discs per beat (centres Q12.4, velocities Q10.6,
// masses Q8.8, both_active); out_o carries one result per beat: hit,
// degenerate, the new velocities and the mass-weighted contact point.
// cfg_we_i/cfg_wdata_i load hit_scale (Q4.12); write it only while idle.
// Throughput: one beat per cycle while out_o is not stalled. The depth is
// set by the two divider pipelines, one quotient bit per stage: 36 stages
// for the division by the mass sum, 19 for the division by the squared
// centre distance.
// The whole pipeline moves together: when out_o holds an unaccepted result
// and the receiver is not ready, every stage holds and in_i.ready drops;
// nothing is lost or repeated. Bubbles travel as cleared valid bits.
// Reset clears all valid bits and sets hit_scale to 1.0; no clearing pass.
module disc_elastic_collision_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [dec_pkg::CfgW-1:0]  cfg_wdata_i,
  dec_stream_if.sink                in_i,
  dec_stream_if.source              out_o
);
  import dec_pkg::*;

  localparam int MsumNumW = 51;
  localparam int MsumDenW = 17;
  localparam int MsumQuoW = 36;
  localparam int D2NumW   = 54;
  localparam int D2DenW   = 34;
  localparam int D2QuoW   = 19;

  typedef struct packed {
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [16:0] dvx;
    logic signed [16:0] dvy;
    logic        [16:0] msum;
    logic        [32:0] r;
    logic signed [32:0] cax;
    logic signed [32:0] cbx;
    logic signed [32:0] cay;
    logic signed [32:0] cby;
    logic signed [16:0] sx;
    logic signed [16:0] sy;
    logic signed [15:0] v1x;
    logic signed [15:0] v1y;
    logic signed [15:0] v2x;
    logic signed [15:0] v2y;
    logic        [15:0] m1;
    logic        [15:0] m2;
    logic               active;
  } s2_t;

  typedef struct packed {
    logic        [32:0] dxx;
    logic        [32:0] dyy;
    logic signed [33:0] kx;
    logic signed [33:0] ky;
    logic        [33:0] aa;
    logic        [32:0] ab;
    logic        [31:0] bb;
    logic signed [33:0] cnx;
    logic signed [33:0] cny;
    logic signed [16:0] midx;
    logic signed [16:0] midy;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic        [16:0] msum;
    logic signed [15:0] v1x;
    logic signed [15:0] v1y;
    logic signed [15:0] v2x;
    logic signed [15:0] v2y;
    logic        [15:0] m1;
    logic        [15:0] m2;
    logic               active;
  } s3_t;

  typedef struct packed {
    logic        [33:0] d2;
    logic signed [34:0] k;
    logic        [65:0] r2;
    logic        [33:0] cmagx;
    logic        [33:0] cmagy;
    logic               cnegx;
    logic               cnegy;
    logic signed [16:0] midx;
    logic signed [16:0] midy;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic        [16:0] msum;
    logic signed [15:0] v1x;
    logic signed [15:0] v1y;
    logic signed [15:0] v2x;
    logic signed [15:0] v2y;
    logic        [15:0] m1;
    logic        [15:0] m2;
    logic               active;
  } s4_t;

  typedef struct packed {
    logic               hitp;
    logic        [33:0] d2;
    logic        [33:0] kmag;
    logic               kneg;
    logic        [33:0] cmagx;
    logic        [33:0] cmagy;
    logic               cnegx;
    logic               cnegy;
    logic signed [16:0] midx;
    logic signed [16:0] midy;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic        [16:0] msum;
    logic signed [15:0] v1x;
    logic signed [15:0] v1y;
    logic signed [15:0] v2x;
    logic signed [15:0] v2y;
    logic        [15:0] m1;
    logic        [15:0] m2;
  } s5_t;

  // Side data that rides alongside the mass-sum dividers
  typedef struct packed {
    logic               hit;
    logic               degen;
    logic signed [15:0] v1x;
    logic signed [15:0] v1y;
    logic signed [15:0] v2x;
    logic signed [15:0] v2y;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic        [33:0] d2;
    logic               kneg;
    logic               cnegx;
    logic               cnegy;
    logic               mzero;
    logic signed [16:0] midx;
    logic signed [16:0] midy;
  } sa_t;

  typedef struct packed {
    logic [MsumNumW-1:0] n1;
    logic [MsumNumW-1:0] n2;
    logic [MsumNumW-1:0] ncx;
    logic [MsumNumW-1:0] ncy;
    logic [16:0]         msum;
    sa_t                 sa;
  } s6_t;

  // Side data that rides alongside the distance dividers
  typedef struct packed {
    logic               hit;
    logic               degen;
    logic signed [15:0] v1x;
    logic signed [15:0] v1y;
    logic signed [15:0] v2x;
    logic signed [15:0] v2y;
    logic               neg1x;
    logic               neg1y;
    logic               neg2x;
    logic               neg2y;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
  } sb_t;

  typedef struct packed {
    logic [D2NumW-1:0] n1x;
    logic [D2NumW-1:0] n1y;
    logic [D2NumW-1:0] n2x;
    logic [D2NumW-1:0] n2y;
    logic [33:0]       d2;
    sb_t               sb;
  } s7_t;

  // Half of a 17-bit signed sum, rounded half away from zero
  function automatic logic signed [16:0] half_round(input logic signed [16:0] s);
    logic [16:0] mag;
    logic [16:0] h;
    mag = s[16] ? 17'(-s) : s;
    h   = (mag + 17'd1) >> 1;
    return s[16] ? 17'(-h) : h;
  endfunction

  // Add a signed correction to a velocity and clamp
  function automatic logic signed [15:0] add_vel(input logic signed [15:0] v,
                                                 input logic [D2QuoW-1:0] q,
                                                 input logic neg);
    logic [20:0] qs;
    logic [20:0] sum;
    qs  = neg ? 21'(-{2'b0, q}) : {2'b0, q};
    sum = {{5{v[15]}}, v} + qs;
    return sat16({{19{sum[20]}}, sum});
  endfunction

  logic [CfgW-1:0] hit_scale_q;
  logic            adv;

  logic  s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q, s6_vld_q, s7_vld_q;
  logic  vld_a, vld_b, out_vld_q;
  in_t   s1_q;
  s2_t   s2_d, s2_q;
  s3_t   s3_d, s3_q;
  s4_t   s4_d, s4_q;
  s5_t   s5_d, s5_q;
  s6_t   s6_d, s6_q;
  s7_t   s7_d, s7_q;
  out_t  out_d, out_q;
  sa_t   sa;
  sb_t   sb;

  logic [MsumQuoW-1:0] qa1, qa2, qacx, qacy;
  logic [D2QuoW-1:0]   qb1x, qb1y, qb2x, qb2y;

  // Whole pipeline advances unless a finished beat is stuck at the output
  assign adv       = !out_vld_q || out_o.ready;
  assign in_i.ready = adv;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_scale_q <= HitScaleRst;
    end else if (cfg_we_i) begin
      hit_scale_q <= cfg_wdata_i;
    end
  end

  // Stage 2: differences, mass sum, radius and contact products
  always_comb begin
    s2_d.dx   = {s1_q.first_pos_x[15], s1_q.first_pos_x}
              - {s1_q.second_pos_x[15], s1_q.second_pos_x};
    s2_d.dy   = {s1_q.first_pos_y[15], s1_q.first_pos_y}
              - {s1_q.second_pos_y[15], s1_q.second_pos_y};
    s2_d.dvx  = {s1_q.second_vel_x[15], s1_q.second_vel_x}
              - {s1_q.first_vel_x[15], s1_q.first_vel_x};
    s2_d.dvy  = {s1_q.second_vel_y[15], s1_q.second_vel_y}
              - {s1_q.first_vel_y[15], s1_q.first_vel_y};
    s2_d.msum = {1'b0, s1_q.first_mass} + {1'b0, s1_q.second_mass};
    s2_d.r    = hit_scale_q * s2_d.msum;
    s2_d.cax  = s1_q.first_pos_x * $signed({1'b0, s1_q.second_mass});
    s2_d.cbx  = s1_q.second_pos_x * $signed({1'b0, s1_q.first_mass});
    s2_d.cay  = s1_q.first_pos_y * $signed({1'b0, s1_q.second_mass});
    s2_d.cby  = s1_q.second_pos_y * $signed({1'b0, s1_q.first_mass});
    s2_d.sx   = {s1_q.first_pos_x[15], s1_q.first_pos_x}
              + {s1_q.second_pos_x[15], s1_q.second_pos_x};
    s2_d.sy   = {s1_q.first_pos_y[15], s1_q.first_pos_y}
              + {s1_q.second_pos_y[15], s1_q.second_pos_y};
    s2_d.v1x  = s1_q.first_vel_x;
    s2_d.v1y  = s1_q.first_vel_y;
    s2_d.v2x  = s1_q.second_vel_x;
    s2_d.v2y  = s1_q.second_vel_y;
    s2_d.m1   = s1_q.first_mass;
    s2_d.m2   = s1_q.second_mass;
    s2_d.active = s1_q.both_active;
  end

  // Stage 3: squares, dot-product terms, radius partial products
  always_comb begin
    logic signed [33:0] sqx;
    logic signed [33:0] sqy;
    sqx = s2_q.dx * s2_q.dx;
    sqy = s2_q.dy * s2_q.dy;
    s3_d.dxx  = sqx[32:0];
    s3_d.dyy  = sqy[32:0];
    s3_d.kx   = s2_q.dvx * s2_q.dx;
    s3_d.ky   = s2_q.dvy * s2_q.dy;
    s3_d.aa   = s2_q.r[32:16] * s2_q.r[32:16];
    s3_d.ab   = s2_q.r[32:16] * s2_q.r[15:0];
    s3_d.bb   = s2_q.r[15:0] * s2_q.r[15:0];
    s3_d.cnx  = s2_q.cax + s2_q.cbx;
    s3_d.cny  = s2_q.cay + s2_q.cby;
    s3_d.midx = half_round(s2_q.sx);
    s3_d.midy = half_round(s2_q.sy);
    s3_d.dx   = s2_q.dx;
    s3_d.dy   = s2_q.dy;
    s3_d.msum = s2_q.msum;
    s3_d.v1x  = s2_q.v1x;
    s3_d.v1y  = s2_q.v1y;
    s3_d.v2x  = s2_q.v2x;
    s3_d.v2y  = s2_q.v2y;
    s3_d.m1   = s2_q.m1;
    s3_d.m2   = s2_q.m2;
    s3_d.active = s2_q.active;
  end

  // Stage 4: squared distance, dot product, squared radius, contact magnitude
  always_comb begin
    logic [33:0] cabsx;
    logic [33:0] cabsy;
    cabsx = s3_q.cnx[33] ? 34'(-s3_q.cnx) : s3_q.cnx;
    cabsy = s3_q.cny[33] ? 34'(-s3_q.cny) : s3_q.cny;
    s4_d.d2    = {1'b0, s3_q.dxx} + {1'b0, s3_q.dyy};
    s4_d.k     = {s3_q.kx[33], s3_q.kx} + {s3_q.ky[33], s3_q.ky};
    s4_d.r2    = {s3_q.aa, 32'b0} + {16'b0, s3_q.ab, 17'b0} + {34'b0, s3_q.bb};
    s4_d.cmagx = cabsx + {18'b0, s3_q.msum[16:1]};
    s4_d.cmagy = cabsy + {18'b0, s3_q.msum[16:1]};
    s4_d.cnegx = s3_q.cnx[33];
    s4_d.cnegy = s3_q.cny[33];
    s4_d.midx  = s3_q.midx;
    s4_d.midy  = s3_q.midy;
    s4_d.dx    = s3_q.dx;
    s4_d.dy    = s3_q.dy;
    s4_d.msum  = s3_q.msum;
    s4_d.v1x   = s3_q.v1x;
    s4_d.v1y   = s3_q.v1y;
    s4_d.v2x   = s3_q.v2x;
    s4_d.v2y   = s3_q.v2y;
    s4_d.m1    = s3_q.m1;
    s4_d.m2    = s3_q.m2;
    s4_d.active = s3_q.active;
  end

  // Stage 5: hit test and magnitude of the dot product
  always_comb begin
    logic [34:0] kabs;
    kabs = s4_q.k[34] ? 35'(-s4_q.k) : s4_q.k;
    s5_d.hitp  = s4_q.active && ({s4_q.d2, 32'b0} < s4_q.r2);
    s5_d.d2    = s4_q.d2;
    s5_d.kmag  = kabs[33:0];
    s5_d.kneg  = s4_q.k[34];
    s5_d.cmagx = s4_q.cmagx;
    s5_d.cmagy = s4_q.cmagy;
    s5_d.cnegx = s4_q.cnegx;
    s5_d.cnegy = s4_q.cnegy;
    s5_d.midx  = s4_q.midx;
    s5_d.midy  = s4_q.midy;
    s5_d.dx    = s4_q.dx;
    s5_d.dy    = s4_q.dy;
    s5_d.msum  = s4_q.msum;
    s5_d.v1x   = s4_q.v1x;
    s5_d.v1y   = s4_q.v1y;
    s5_d.v2x   = s4_q.v2x;
    s5_d.v2y   = s4_q.v2y;
    s5_d.m1    = s4_q.m1;
    s5_d.m2    = s4_q.m2;
  end

  // Stage 6: impulse numerators with the rounding half-divisor added
  always_comb begin
    s6_d.n1   = s5_q.kmag * {s5_q.m2, 1'b0} + {35'b0, s5_q.msum[16:1]};
    s6_d.n2   = s5_q.kmag * {s5_q.m1, 1'b0} + {35'b0, s5_q.msum[16:1]};
    s6_d.ncx  = {17'b0, s5_q.cmagx};
    s6_d.ncy  = {17'b0, s5_q.cmagy};
    s6_d.msum = s5_q.msum;
    s6_d.sa.hit   = s5_q.hitp && (s5_q.d2 != '0);
    s6_d.sa.degen = s5_q.hitp && (s5_q.d2 == '0);
    s6_d.sa.v1x   = s5_q.v1x;
    s6_d.sa.v1y   = s5_q.v1y;
    s6_d.sa.v2x   = s5_q.v2x;
    s6_d.sa.v2y   = s5_q.v2y;
    s6_d.sa.dx    = s5_q.dx;
    s6_d.sa.dy    = s5_q.dy;
    s6_d.sa.d2    = s5_q.d2;
    s6_d.sa.kneg  = s5_q.kneg;
    s6_d.sa.cnegx = s5_q.cnegx;
    s6_d.sa.cnegy = s5_q.cnegy;
    s6_d.sa.mzero = (s5_q.msum == '0);
    s6_d.sa.midx  = s5_q.midx;
    s6_d.sa.midy  = s5_q.midy;
  end

  // Front stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_i.valid;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= in_i.data;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
      s5_q <= s5_d;
      s6_q <= s6_d;
    end
  end

  // Divide by the mass sum: both impulses and both contact coordinates
  dec_div #(.NUM_W(MsumNumW), .DEN_W(MsumDenW), .QUO_W(MsumQuoW)) u_div_t1 (
    .clk_i, .en_i(adv), .num_i(s6_q.n1), .den_i(s6_q.msum), .quo_o(qa1)
  );
  dec_div #(.NUM_W(MsumNumW), .DEN_W(MsumDenW), .QUO_W(MsumQuoW)) u_div_t2 (
    .clk_i, .en_i(adv), .num_i(s6_q.n2), .den_i(s6_q.msum), .quo_o(qa2)
  );
  dec_div #(.NUM_W(MsumNumW), .DEN_W(MsumDenW), .QUO_W(MsumQuoW)) u_div_cx (
    .clk_i, .en_i(adv), .num_i(s6_q.ncx), .den_i(s6_q.msum), .quo_o(qacx)
  );
  dec_div #(.NUM_W(MsumNumW), .DEN_W(MsumDenW), .QUO_W(MsumQuoW)) u_div_cy (
    .clk_i, .en_i(adv), .num_i(s6_q.ncy), .den_i(s6_q.msum), .quo_o(qacy)
  );

  dec_dly #(.W(1), .N(MsumQuoW)) u_vld_a (
    .clk_i, .rst_ni, .en_i(adv), .d_i(s6_vld_q), .q_o(vld_a)
  );
  dec_dly #(.W($bits(sa_t)), .N(MsumQuoW)) u_side_a (
    .clk_i, .rst_ni, .en_i(adv), .d_i(s6_q.sa), .q_o(sa)
  );

  // Stage 7: velocity numerators, signs and the finished contact point
  always_comb begin
    logic        [16:0] adx;
    logic        [16:0] ady;
    logic signed [36:0] cxs;
    logic signed [36:0] cys;
    adx = sa.dx[16] ? 17'(-sa.dx) : sa.dx;
    ady = sa.dy[16] ? 17'(-sa.dy) : sa.dy;
    cxs = sa.cnegx ? 37'(-{1'b0, qacx}) : {1'b0, qacx};
    cys = sa.cnegy ? 37'(-{1'b0, qacy}) : {1'b0, qacy};
    s7_d.n1x = qa1 * adx + {21'b0, sa.d2[33:1]};
    s7_d.n1y = qa1 * ady + {21'b0, sa.d2[33:1]};
    s7_d.n2x = qa2 * adx + {21'b0, sa.d2[33:1]};
    s7_d.n2y = qa2 * ady + {21'b0, sa.d2[33:1]};
    s7_d.d2  = sa.d2;
    s7_d.sb.hit   = sa.hit;
    s7_d.sb.degen = sa.degen;
    s7_d.sb.v1x   = sa.v1x;
    s7_d.sb.v1y   = sa.v1y;
    s7_d.sb.v2x   = sa.v2x;
    s7_d.sb.v2y   = sa.v2y;
    s7_d.sb.neg1x = sa.kneg ^ sa.dx[16];
    s7_d.sb.neg1y = sa.kneg ^ sa.dy[16];
    s7_d.sb.neg2x = !sa.kneg ^ sa.dx[16];
    s7_d.sb.neg2y = !sa.kneg ^ sa.dy[16];
    s7_d.sb.cx = sa.mzero ? sat16({{23{sa.midx[16]}}, sa.midx})
                          : sat16({{3{cxs[36]}}, cxs});
    s7_d.sb.cy = sa.mzero ? sat16({{23{sa.midy[16]}}, sa.midy})
                          : sat16({{3{cys[36]}}, cys});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_vld_q <= 1'b0;
    end else if (adv) begin
      s7_vld_q <= vld_a;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_q <= s7_d;
    end
  end

  // Divide by the squared distance for each velocity component
  dec_div #(.NUM_W(D2NumW), .DEN_W(D2DenW), .QUO_W(D2QuoW)) u_div_1x (
    .clk_i, .en_i(adv), .num_i(s7_q.n1x), .den_i(s7_q.d2), .quo_o(qb1x)
  );
  dec_div #(.NUM_W(D2NumW), .DEN_W(D2DenW), .QUO_W(D2QuoW)) u_div_1y (
    .clk_i, .en_i(adv), .num_i(s7_q.n1y), .den_i(s7_q.d2), .quo_o(qb1y)
  );
  dec_div #(.NUM_W(D2NumW), .DEN_W(D2DenW), .QUO_W(D2QuoW)) u_div_2x (
    .clk_i, .en_i(adv), .num_i(s7_q.n2x), .den_i(s7_q.d2), .quo_o(qb2x)
  );
  dec_div #(.NUM_W(D2NumW), .DEN_W(D2DenW), .QUO_W(D2QuoW)) u_div_2y (
    .clk_i, .en_i(adv), .num_i(s7_q.n2y), .den_i(s7_q.d2), .quo_o(qb2y)
  );

  dec_dly #(.W(1), .N(D2QuoW)) u_vld_b (
    .clk_i, .rst_ni, .en_i(adv), .d_i(s7_vld_q), .q_o(vld_b)
  );
  dec_dly #(.W($bits(sb_t)), .N(D2QuoW)) u_side_b (
    .clk_i, .rst_ni, .en_i(adv), .d_i(s7_q.sb), .q_o(sb)
  );

  // Output stage: apply the corrections on a hit, else pass velocities through
  always_comb begin
    out_d.hit        = sb.hit;
    out_d.degenerate = sb.degen;
    out_d.new_first_vel_x  = sb.hit ? add_vel(sb.v1x, qb1x, sb.neg1x) : sb.v1x;
    out_d.new_first_vel_y  = sb.hit ? add_vel(sb.v1y, qb1y, sb.neg1y) : sb.v1y;
    out_d.new_second_vel_x = sb.hit ? add_vel(sb.v2x, qb2x, sb.neg2x) : sb.v2x;
    out_d.new_second_vel_y = sb.hit ? add_vel(sb.v2y, qb2y, sb.neg2y) : sb.v2y;
    out_d.contact_x  = sb.cx;
    out_d.contact_y  = sb.cy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // A result never claims both a response and coincident centres
  a_hit_degen_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_q.hit && out_q.degenerate))
    else $error("hit and degenerate both set");

  // An accepted beat lands in the first stage
  a_accept_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> s1_vld_q)
    else $error("accepted beat lost at entry");

  // A stall freezes the valid bits inside the pipeline (checked on s6 and s7)
  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(s6_vld_q) && $stable(s7_vld_q))
    else $error("pipeline moved during stall");

endmodule

FILE: src/dec_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// The quotient must fit in QUO_W bits.
module dec_div #(
  parameter int NUM_W = 51,
  parameter int DEN_W = 17,
  parameter int QUO_W = 36
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o
);

  logic [DEN_W-1:0] rem_q [QUO_W];
  logic [QUO_W-1:0] low_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];

  logic [DEN_W-1:0] rem_in [QUO_W];
  logic [QUO_W-1:0] low_in [QUO_W];
  logic [QUO_W-1:0] quo_in [QUO_W];
  logic [DEN_W-1:0] den_in [QUO_W];

  // Upper numerator bits stay below the divisor, so they seed the remainder
  assign rem_in[0] = DEN_W'(num_i >> QUO_W);
  assign low_in[0] = num_i[QUO_W-1:0];
  assign quo_in[0] = '0;
  assign den_in[0] = den_i;

  for (genvar s = 1; s < QUO_W; s++) begin : g_link
    assign rem_in[s] = rem_q[s-1];
    assign low_in[s] = low_q[s-1];
    assign quo_in[s] = quo_q[s-1];
    assign den_in[s] = den_q[s-1];
  end

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic [DEN_W:0] trial;
    logic           ge;

    // Bring down one numerator bit and try a subtract
    assign trial = {rem_in[s], low_in[s][QUO_W-1]};
    assign ge    = trial >= {1'b0, den_in[s]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? DEN_W'(trial - {1'b0, den_in[s]}) : trial[DEN_W-1:0];
        low_q[s] <= low_in[s] << 1;
        quo_q[s] <= {quo_in[s][QUO_W-2:0], ge};
        den_q[s] <= den_in[s];
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

FILE: src/dec_dly.sv
// Enabled delay line that keeps side data in step with the dividers.
module dec_dly #(
  parameter int W = 1,
  parameter int N = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] dly_q [N];

  // Advance all taps together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) begin
        dly_q[i] <= '0;
      end
    end else if (en_i) begin
      dly_q[0] <= d_i;
      for (int i = 1; i < N; i++) begin
        dly_q[i] <= dly_q[i-1];
      end
    end
  end

  assign q_o = dly_q[N-1];

endmodule

FILE: tb/disc_elastic_collision_top_test.sv
`timescale 1ns / 100ps

module disc_elastic_collision_top_test;
  import dec_pkg::*;

  localparam int Latency  = 62;
  localparam int MaxCycle = 1500000;

  // Expected result store and checker
  class collision_board;
    out_t pending_q[$];
    int   fail_cnt;

    function void note_pair(out_t exp_beat);
      pending_q = {pending_q, exp_beat};
    endfunction

    function void check_result(out_t got);
      out_t e;
      if (pending_q.size() == 0) begin
        $error("result beat with nothing expected");
        fail_cnt++;
        return;
      end
      e = pending_q.pop_front();
      if (got.hit !== e.hit) begin
        $error("hit: expected %0d actual %0d", e.hit, got.hit);
        fail_cnt++;
      end
      if (got.degenerate !== e.degenerate) begin
        $error("degenerate: expected %0d actual %0d", e.degenerate, got.degenerate);
        fail_cnt++;
      end
      if (got.new_first_vel_x !== e.new_first_vel_x) begin
        $error("new_first_vel_x: expected %0d actual %0d",
               e.new_first_vel_x, got.new_first_vel_x);
        fail_cnt++;
      end
      if (got.new_first_vel_y !== e.new_first_vel_y) begin
        $error("new_first_vel_y: expected %0d actual %0d",
               e.new_first_vel_y, got.new_first_vel_y);
        fail_cnt++;
      end
      if (got.new_second_vel_x !== e.new_second_vel_x) begin
        $error("new_second_vel_x: expected %0d actual %0d",
               e.new_second_vel_x, got.new_second_vel_x);
        fail_cnt++;
      end
      if (got.new_second_vel_y !== e.new_second_vel_y) begin
        $error("new_second_vel_y: expected %0d actual %0d",
               e.new_second_vel_y, got.new_second_vel_y);
        fail_cnt++;
      end
      if (got.contact_x !== e.contact_x) begin
        $error("contact_x: expected %0d actual %0d", e.contact_x, got.contact_x);
        fail_cnt++;
      end
      if (got.contact_y !== e.contact_y) begin
        $error("contact_y: expected %0d actual %0d", e.contact_y, got.contact_y);
        fail_cnt++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CfgW-1:0]  cfg_wdata_i;
  logic [CfgW-1:0]  scale_q;
  int               send_idle_pct;
  int               recv_stall_pct;
  longint           cycle_cnt = 0;
  collision_board   board;

  dec_stream_if #(.T(in_t))  pair_if ();
  dec_stream_if #(.T(out_t)) resp_if ();

  disc_elastic_collision_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (pair_if.sink),
    .out_o       (resp_if.source)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Divide rounding to nearest, ties away from zero
  function automatic longint round_div(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Predict the response of one disc pair
  function automatic out_t predict_collision(in_t p, logic [15:0] scale);
    out_t   r;
    longint dx, dy, k1, t1, t2, cx, cy;
    longint v1x, v1y, v2x, v2y, m1, m2, msum;
    longint n1x, n1y, n2x, n2y;
    logic [127:0] d2, rad, lhs, rhs;
    dx = longint'(p.first_pos_x) - longint'(p.second_pos_x);
    dy = longint'(p.first_pos_y) - longint'(p.second_pos_y);
    v1x = p.first_vel_x;  v1y = p.first_vel_y;
    v2x = p.second_vel_x; v2y = p.second_vel_y;
    m1 = p.first_mass; m2 = p.second_mass;
    msum = m1 + m2;
    d2 = 128'(dx * dx + dy * dy);
    rad = 128'(longint'(scale) * msum);
    lhs = d2 << 32;
    rhs = rad * rad;
    n1x = v1x; n1y = v1y; n2x = v2x; n2y = v2y;
    r.hit = 1'b0;
    r.degenerate = 1'b0;
    if (p.both_active && lhs < rhs) begin
      if (d2 == 0) begin
        r.degenerate = 1'b1;
      end else begin
        k1 = (v2x - v1x) * dx + (v2y - v1y) * dy;
        t1 = round_div(k1 * 2 * m2, msum);
        t2 = round_div(-k1 * 2 * m1, msum);
        n1x = v1x + round_div(t1 * dx, longint'(d2));
        n1y = v1y + round_div(t1 * dy, longint'(d2));
        n2x = v2x + round_div(t2 * dx, longint'(d2));
        n2y = v2y + round_div(t2 * dy, longint'(d2));
        r.hit = 1'b1;
      end
    end
    if (msum != 0) begin
      cx = round_div(longint'(p.first_pos_x) * m2 + longint'(p.second_pos_x) * m1, msum);
      cy = round_div(longint'(p.first_pos_y) * m2 + longint'(p.second_pos_y) * m1, msum);
    end else begin
      cx = round_div(longint'(p.first_pos_x) + longint'(p.second_pos_x), 2);
      cy = round_div(longint'(p.first_pos_y) + longint'(p.second_pos_y), 2);
    end
    r.new_first_vel_x  = clamp16(n1x);
    r.new_first_vel_y  = clamp16(n1y);
    r.new_second_vel_x = clamp16(n2x);
    r.new_second_vel_y = clamp16(n2y);
    r.contact_x = clamp16(cx);
    r.contact_y = clamp16(cy);
    return r;
  endfunction

  // Push one pair beat, idling first at the set rate
  task automatic send_pair(in_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      pair_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pair_if.valid <= 1'b1;
    pair_if.data  <= p;
    @(posedge clk_i);
    while (!pair_if.ready) @(posedge clk_i);
    board.note_pair(predict_collision(p, scale_q));
  endtask

  task automatic write_scale(logic [15:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    scale_q = v;
  endtask

  // Hold until all results are back, then let the pipeline settle
  task automatic drain();
    pair_if.valid <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($signed($urandom_range(64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_mass();
    case ($urandom_range(3))
      0: return 16'hffff;
      1: return 16'($urandom_range(512, 1));
      default: return 16'($urandom_range(65535, 1));
    endcase
  endfunction

  // Random pair, mostly placed near enough to collide
  function automatic in_t random_pair(logic [15:0] scale);
    in_t    p;
    longint reach;
    int     span;
    p.first_pos_x = pick16();
    p.first_pos_y = pick16();
    p.first_vel_x = pick16();
    p.first_vel_y = pick16();
    p.second_vel_x = pick16();
    p.second_vel_y = pick16();
    p.first_mass = pick_mass();
    p.second_mass = pick_mass();
    p.both_active = ($urandom_range(9) != 0);
    if ($urandom_range(9) < 7) begin
      reach = (longint'(scale) * (p.first_mass + p.second_mass)) >>> 16;
      span = (reach > 20000) ? 20000 : int'(reach) + 2;
      p.second_pos_x = p.first_pos_x + 16'($urandom_range(2 * span) - span);
      p.second_pos_y = p.first_pos_y + 16'($urandom_range(2 * span) - span);
      if ($urandom_range(30) == 0) begin
        p.second_pos_x = p.first_pos_x;
        p.second_pos_y = p.first_pos_y;
      end
    end else begin
      p.second_pos_x = pick16();
      p.second_pos_y = pick16();
    end
    return p;
  endfunction

  // Receiver: stall at the set rate, check every accepted beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resp_if.ready <= 1'b0;
    end else begin
      if (resp_if.valid && resp_if.ready) board.check_result(resp_if.data);
      resp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Abort on runaway
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MaxCycle) begin
      $display("disc_elastic_collision_top_test NOT OK");
      $finish;
    end
  end

  initial begin
    in_t          p;
    logic [15:0]  scales [6];
    int           idle_tab [4][2];
    board = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    scale_q = HitScaleRst;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    pair_if.valid = 1'b0;
    pair_if.data = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, coincident centres, inactive pair, heavy/light masses
    for (int i = 0; i < 20; i++) begin
      p = random_pair(scale_q);
      case (i)
        0: p = '{16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000,
                 16'h8000, 16'h7fff, 16'hffff, 16'hffff, 1'b1};
        1: p = '{16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff,
                 16'h7fff, 16'h8000, 16'h0001, 16'h0001, 1'b1};
        2: p = '{16'd5, 16'd5, 16'd5, 16'd5, 16'd100, 16'd0, 16'd0, 16'd0,
                 16'd256, 16'd256, 1'b1};
        3: p = '{16'd0, 16'd0, 16'd16, 16'd0, 16'd64, 16'd0, 16'hffc0, 16'd0,
                 16'd256, 16'd256, 1'b1};
        4: p = '{16'd0, 16'd0, 16'd16, 16'd0, 16'd64, 16'd0, 16'hffc0, 16'd0,
                 16'd256, 16'd256, 1'b0};
        5: p = '{16'd0, 16'd0, 16'd16, 16'd16, 16'h7fff, 16'h7fff, 16'h8000,
                 16'h8000, 16'hffff, 16'h0001, 1'b1};
        6: p = '{16'h7fff, 16'h0, 16'h7ff0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                 16'h0001, 16'hffff, 1'b1};
        default: ;
      endcase
      send_pair(p);
    end
    drain();

    scales = '{16'h0000, 16'hffff, 16'h0001, 16'h1000, 16'h0400, 16'h4000};
    idle_tab = '{'{0, 0}, '{77, 0}, '{0, 77}, '{30, 30}};
    foreach (scales[s]) begin
      write_scale(scales[s]);
      for (int ph = 0; ph < 4; ph++) begin
        send_idle_pct = idle_tab[ph][0];
        recv_stall_pct = idle_tab[ph][1];
        for (int i = 0; i < 81; i++) send_pair(random_pair(scale_q));
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain();
    end

    if (board.fail_cnt == 0 && board.pending_q.size() == 0) begin
      $display("disc_elastic_collision_top_test OK");
    end else begin
      $display("disc_elastic_collision_top_test NOT OK");
    end
    $finish;
  end

endmodule
